// File: rtl/core/transpose_ranking_list_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the transpose ranking list
// Concurrent checks that can be compiled out by defining ASSERT_OFF.
// ----------------------------------------------------------------------------
`ifndef TRANSPOSE_RANKING_LIST_DEFINES_SVH
`define TRANSPOSE_RANKING_LIST_DEFINES_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, checked on every rising edge outside reset.
`define TRL_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("trl: same-cycle implication violated");
// Next-cycle implication, checked on every rising edge outside reset.
`define TRL_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("trl: next-cycle implication violated");
`else
`define TRL_ASSERT_IMPL(name, clk, rst_n, ante, cons)
`define TRL_ASSERT_NEXT(name, clk, rst_n, ante, cons)
`endif

`endif

// File: rtl/core/trl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Transpose ranking list package
// Shared widths, codes, state encoding and controller/datapath structs.
// ----------------------------------------------------------------------------
package trl_pkg;

    localparam int TRL_DEPTH     = 64;
    localparam int TRL_KEY_WIDTH = 32;

    localparam int OP_W     = 3;
    localparam int KEY_W    = 32;
    localparam int RANK_W   = 7;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 7;
    localparam int KEY_EXT_W = 64;

    typedef enum logic [OP_W-1:0] {
        OP_APPEND   = 3'd0,
        OP_ADD      = 3'd1,
        OP_CONTAINS = 3'd2,
        OP_GET      = 3'd3,
        OP_DOWN     = 3'd4,
        OP_READ_TOP = 3'd5
    } t_trl_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK   = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2
    } t_trl_status_code;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_APPEND,
        S_SEARCH,
        S_RD_HI,
        S_RD_LO,
        S_CAP_LO,
        S_WR_LO,
        S_WR_HI,
        S_RESULT,
        S_TOP_RD,
        S_TOP_EMIT
    } t_trl_state;

    typedef enum logic [1:0] {
        RD_NONE,
        RD_IDX,
        RD_P,
        RD_PM1
    } t_trl_rd_sel;

    typedef enum logic [1:0] {
        WR_NONE,
        WR_APPEND,
        WR_LO,
        WR_HI
    } t_trl_wr_sel;

    typedef enum logic {
        OUT_RESULT,
        OUT_TOP
    } t_trl_out_sel;

    typedef struct packed {
        logic             in_ld;
        logic             idx_clr;
        logic             idx_inc;
        t_trl_rd_sel      rd_sel;
        t_trl_wr_sel      wr_sel;
        logic             p_ld_rank;
        logic             hi_ld;
        logic             lo_ld;
        logic             swap_ld;
        logic             status_ld;
        t_trl_status_code status_val;
        logic             out_ld;
        t_trl_out_sel     out_sel;
    } t_trl_cmd;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            count_zero;
        logic            count_full;
        logic            rank_bad;
        logic            rank_is_count;
        logic            top_zero;
        logic            top_last;
        logic            issue_done;
        logic            cmp_vld;
        logic            cmp_hit;
        logic            cmp_last;
        logic            pos_zero;
        logic            p_zero;
        logic            out_busy;
    } t_trl_sts;

endpackage

// File: rtl/core/trl_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Transpose ranking list request channel
// Valid/ready channel carrying one operation request per beat.
// ----------------------------------------------------------------------------
interface trl_in_if
    import trl_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   operation;
    logic [KEY_W-1:0]  key;
    logic [RANK_W-1:0] rank;

    modport source (output valid, output operation, output key, output rank, input ready);
    modport sink   (input valid, input operation, input key, input rank, output ready);
endinterface

// File: rtl/core/trl_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Transpose ranking list result channel
// Valid/ready channel carrying one result beat.
// ----------------------------------------------------------------------------
interface trl_out_if
    import trl_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [KEY_W-1:0]    key_out;
    logic [RANK_W-1:0]   rank_out;
    logic [COUNT_W-1:0]  entry_count;
    logic                last;

    modport source (output valid, output status, output key_out, output rank_out,
                    output entry_count, output last, input ready);
    modport sink   (input valid, input status, input key_out, input rank_out,
                    input entry_count, input last, output ready);
endinterface

// File: rtl/core/trl_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Transpose ranking list controller
// Sequences search, swap, append and read-out steps over the datapath.
// ----------------------------------------------------------------------------
`include "transpose_ranking_list_defines.svh"

module trl_ctrl
    import trl_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_trl_sts i_sts,
    output t_trl_cmd o_cmd
);

    t_trl_state r_state;
    t_trl_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                case (i_sts.op)
                    OP_APPEND: n_state = S_APPEND;
                    OP_ADD: begin
                        n_state = i_sts.count_zero ? S_APPEND : S_SEARCH;
                    end
                    OP_CONTAINS: begin
                        n_state = i_sts.count_zero ? S_RESULT : S_SEARCH;
                    end
                    OP_GET: begin
                        n_state = i_sts.rank_bad ? S_RESULT : S_RD_HI;
                    end
                    OP_DOWN: begin
                        n_state = (i_sts.rank_bad || i_sts.rank_is_count) ? S_RESULT : S_RD_HI;
                    end
                    OP_READ_TOP: begin
                        n_state = i_sts.top_zero ? S_RESULT : S_TOP_RD;
                    end
                    default: n_state = S_RESULT;
                endcase
            end
            S_APPEND: n_state = S_RESULT;
            S_SEARCH: begin
                if (i_sts.cmp_vld && i_sts.cmp_hit) begin
                    n_state = i_sts.pos_zero ? S_RESULT : S_WR_LO;
                end else if (i_sts.cmp_vld && i_sts.cmp_last) begin
                    n_state = (i_sts.op == OP_ADD) ? S_APPEND : S_RESULT;
                end
            end
            S_RD_HI: n_state = S_RD_LO;
            S_RD_LO: begin
                n_state = (i_sts.op == OP_GET && i_sts.p_zero) ? S_RESULT : S_CAP_LO;
            end
            S_CAP_LO: n_state = S_WR_LO;
            S_WR_LO:  n_state = S_WR_HI;
            S_WR_HI:  n_state = S_RESULT;
            S_RESULT: begin
                if (!i_sts.out_busy) begin
                    n_state = S_IDLE;
                end
            end
            S_TOP_RD: n_state = S_TOP_EMIT;
            S_TOP_EMIT: begin
                if (!i_sts.out_busy) begin
                    n_state = i_sts.top_last ? S_IDLE : S_TOP_RD;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Commands.
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.in_ld  = i_in_valid;
            end
            S_DISPATCH: begin
                o_cmd.idx_clr = 1'b1;
                case (i_sts.op)
                    OP_APPEND: ;
                    OP_ADD: ;
                    OP_CONTAINS: begin
                        if (i_sts.count_zero) begin
                            o_cmd.status_ld  = 1'b1;
                            o_cmd.status_val = ST_MISS;
                        end
                    end
                    OP_GET: begin
                        if (i_sts.rank_bad) begin
                            o_cmd.status_ld  = 1'b1;
                            o_cmd.status_val = ST_MISS;
                        end else begin
                            o_cmd.p_ld_rank = 1'b1;
                        end
                    end
                    OP_DOWN: begin
                        if (i_sts.rank_bad) begin
                            o_cmd.status_ld  = 1'b1;
                            o_cmd.status_val = ST_MISS;
                        end else if (i_sts.rank_is_count) begin
                            o_cmd.status_ld  = 1'b1;
                            o_cmd.status_val = ST_OK;
                        end else begin
                            o_cmd.p_ld_rank = 1'b1;
                        end
                    end
                    OP_READ_TOP: begin
                        if (i_sts.top_zero) begin
                            o_cmd.status_ld  = 1'b1;
                            o_cmd.status_val = ST_MISS;
                        end
                    end
                    default: begin
                        o_cmd.status_ld  = 1'b1;
                        o_cmd.status_val = ST_MISS;
                    end
                endcase
            end
            S_APPEND: begin
                o_cmd.status_ld = 1'b1;
                if (i_sts.count_full) begin
                    o_cmd.status_val = ST_FULL;
                end else begin
                    o_cmd.status_val = ST_OK;
                    o_cmd.wr_sel     = WR_APPEND;
                end
            end
            S_SEARCH: begin
                if (!i_sts.issue_done) begin
                    o_cmd.rd_sel  = RD_IDX;
                    o_cmd.idx_inc = 1'b1;
                end
                if (i_sts.cmp_vld && i_sts.cmp_hit) begin
                    if (i_sts.pos_zero) begin
                        o_cmd.status_ld  = 1'b1;
                        o_cmd.status_val = ST_OK;
                    end else begin
                        o_cmd.swap_ld = 1'b1;
                    end
                end else if (i_sts.cmp_vld && i_sts.cmp_last && i_sts.op != OP_ADD) begin
                    o_cmd.status_ld  = 1'b1;
                    o_cmd.status_val = ST_MISS;
                end
            end
            S_RD_HI: o_cmd.rd_sel = RD_P;
            S_RD_LO: begin
                o_cmd.hi_ld = 1'b1;
                if (i_sts.op == OP_GET && i_sts.p_zero) begin
                    o_cmd.status_ld  = 1'b1;
                    o_cmd.status_val = ST_OK;
                end else begin
                    o_cmd.rd_sel = RD_PM1;
                end
            end
            S_CAP_LO: o_cmd.lo_ld = 1'b1;
            S_WR_LO:  o_cmd.wr_sel = WR_LO;
            S_WR_HI: begin
                o_cmd.wr_sel     = WR_HI;
                o_cmd.status_ld  = 1'b1;
                o_cmd.status_val = ST_OK;
            end
            S_RESULT: begin
                o_cmd.out_sel = OUT_RESULT;
                o_cmd.out_ld  = !i_sts.out_busy;
            end
            S_TOP_RD: o_cmd.rd_sel = RD_IDX;
            S_TOP_EMIT: begin
                o_cmd.out_sel = OUT_TOP;
                o_cmd.out_ld  = !i_sts.out_busy;
                o_cmd.idx_inc = !i_sts.out_busy;
            end
            default: ;
        endcase
    end

    // A request taken in idle is always decoded in the following cycle.
    `TRL_ASSERT_NEXT(a_accept_dispatch, i_clk, i_rst_n, i_in_valid && o_in_ready, r_state == S_DISPATCH)
    // The result register is never overwritten while a beat still waits in it.
    `TRL_ASSERT_IMPL(a_out_no_overrun, i_clk, i_rst_n, o_cmd.out_ld, !i_sts.out_busy)

endmodule

// File: rtl/core/trl_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Transpose ranking list datapath
// Key store, entry count, scan counter, swap holding registers and result register.
// ----------------------------------------------------------------------------
`include "transpose_ranking_list_defines.svh"

module trl_dp
    import trl_pkg::*;
#(
    parameter int DEPTH     = TRL_DEPTH,
    parameter int KEY_WIDTH = TRL_KEY_WIDTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_trl_cmd            i_cmd,
    output t_trl_sts            o_sts,
    input  logic [OP_W-1:0]     i_operation,
    input  logic [KEY_W-1:0]    i_key,
    input  logic [RANK_W-1:0]   i_rank,
    input  logic                i_out_ready,
    output logic                o_out_valid,
    output logic [STATUS_W-1:0] o_status,
    output logic [KEY_W-1:0]    o_key_out,
    output logic [RANK_W-1:0]   o_rank_out,
    output logic [COUNT_W-1:0]  o_entry_count,
    output logic                o_last
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int XW = (CW > RANK_W) ? CW : RANK_W;

    logic [KEY_WIDTH-1:0] r_mem [DEPTH];

    logic [OP_W-1:0]      r_op;
    logic [KEY_WIDTH-1:0] r_key;
    logic [RANK_W-1:0]    r_rank;
    logic [CW-1:0]        r_count;
    logic [CW-1:0]        r_idx;
    logic                 r_cmp_vld;
    logic [AW-1:0]        r_cmp_idx;
    logic [KEY_WIDTH-1:0] r_prev;
    logic [KEY_WIDTH-1:0] r_hi;
    logic [KEY_WIDTH-1:0] r_lo;
    logic [KEY_WIDTH-1:0] r_rd_data;
    logic [AW-1:0]        r_p;
    t_trl_status_code     r_status;

    logic                r_out_vld;
    logic [STATUS_W-1:0] r_out_status;
    logic [KEY_W-1:0]    r_out_key;
    logic [RANK_W-1:0]   r_out_rank;
    logic [COUNT_W-1:0]  r_out_count;
    logic                r_out_last;

    logic [KEY_EXT_W-1:0] key_in_ext;
    logic [KEY_WIDTH-1:0] key_in_fit;
    logic [KEY_EXT_W-1:0] hi_ext;
    logic [KEY_EXT_W-1:0] rd_ext;
    logic [XW-1:0]        rank_x;
    logic [XW-1:0]        count_x;
    logic [XW-1:0]        idx_x;
    logic [XW-1:0]        idx_next_x;
    logic [XW-1:0]        top_n;
    logic [XW-1:0]        p_src;
    logic [CW-1:0]        cmp_idx_c;
    logic                 rd_en;
    logic [AW-1:0]        rd_addr;
    logic                 wr_en;
    logic [AW-1:0]        wr_addr;
    logic [KEY_WIDTH-1:0] wr_data;
    logic                 top_last;

    // Width adaptation between the fixed port fields and the stored key width.
    always_comb begin
        key_in_ext               = '0;
        key_in_ext[KEY_W-1:0]    = i_key;
        key_in_fit               = key_in_ext[KEY_WIDTH-1:0];
        hi_ext                   = '0;
        hi_ext[KEY_WIDTH-1:0]    = r_hi;
        rd_ext                   = '0;
        rd_ext[KEY_WIDTH-1:0]    = r_rd_data;
        rank_x                   = '0;
        rank_x[RANK_W-1:0]       = r_rank;
        count_x                  = '0;
        count_x[CW-1:0]          = r_count;
        idx_x                    = '0;
        idx_x[CW-1:0]            = r_idx;
    end

    assign idx_next_x = XW'(idx_x + XW'(1));
    assign top_n      = (rank_x < count_x) ? rank_x : count_x;
    assign top_last   = (idx_next_x == top_n);
    assign cmp_idx_c  = CW'(r_cmp_idx);
    assign p_src      = (r_op == OP_GET) ? XW'(rank_x - XW'(1)) : rank_x;

    always_comb begin
        o_sts               = '0;
        o_sts.op            = r_op;
        o_sts.count_zero    = (r_count == '0);
        o_sts.count_full    = (r_count == CW'(DEPTH));
        o_sts.rank_bad      = (rank_x == '0) || (rank_x > count_x);
        o_sts.rank_is_count = (rank_x == count_x);
        o_sts.top_zero      = (top_n == '0);
        o_sts.top_last      = top_last;
        o_sts.issue_done    = (r_idx == r_count);
        o_sts.cmp_vld       = r_cmp_vld;
        o_sts.cmp_hit       = (r_rd_data == r_key);
        o_sts.cmp_last      = (CW'(cmp_idx_c + CW'(1)) == r_count);
        o_sts.pos_zero      = (r_cmp_idx == '0);
        o_sts.p_zero        = (r_p == '0);
        o_sts.out_busy      = r_out_vld && !i_out_ready;
    end

    // Key store ports: one registered read and one write per cycle.
    always_comb begin
        rd_en   = 1'b1;
        rd_addr = r_idx[AW-1:0];
        case (i_cmd.rd_sel)
            RD_IDX:  rd_addr = r_idx[AW-1:0];
            RD_P:    rd_addr = r_p;
            RD_PM1:  rd_addr = AW'(r_p - AW'(1));
            default: rd_en   = 1'b0;
        endcase
    end

    always_comb begin
        wr_en   = 1'b1;
        wr_addr = r_count[AW-1:0];
        wr_data = r_key;
        case (i_cmd.wr_sel)
            WR_APPEND: begin
                wr_addr = r_count[AW-1:0];
                wr_data = r_key;
            end
            WR_LO: begin
                wr_addr = AW'(r_p - AW'(1));
                wr_data = r_hi;
            end
            WR_HI: begin
                wr_addr = r_p;
                wr_data = r_lo;
            end
            default: wr_en = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_idx     <= '0;
            r_cmp_vld <= 1'b0;
            r_out_vld <= 1'b0;
            r_status  <= ST_OK;
        end else begin
            if (i_cmd.wr_sel == WR_APPEND) begin
                r_count <= CW'(r_count + CW'(1));
            end
            if (i_cmd.idx_clr) begin
                r_idx <= '0;
            end else if (i_cmd.idx_inc) begin
                r_idx <= CW'(r_idx + CW'(1));
            end
            r_cmp_vld <= (i_cmd.rd_sel == RD_IDX) && !i_cmd.idx_clr;
            if (i_cmd.status_ld) begin
                r_status <= i_cmd.status_val;
            end
            if (i_cmd.out_ld) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.in_ld) begin
            r_op   <= i_operation;
            r_key  <= key_in_fit;
            r_rank <= i_rank;
        end
        if (i_cmd.rd_sel == RD_IDX) begin
            r_cmp_idx <= r_idx[AW-1:0];
        end
        if (r_cmp_vld) begin
            r_prev <= r_rd_data;
        end
        if (i_cmd.p_ld_rank) begin
            r_p <= p_src[AW-1:0];
        end else if (i_cmd.swap_ld) begin
            r_p <= r_cmp_idx;
        end
        if (i_cmd.hi_ld) begin
            r_hi <= r_rd_data;
        end else if (i_cmd.swap_ld) begin
            r_hi <= r_rd_data;
        end
        if (i_cmd.lo_ld) begin
            r_lo <= r_rd_data;
        end else if (i_cmd.swap_ld) begin
            r_lo <= r_prev;
        end
        if (i_cmd.out_ld) begin
            r_out_count <= count_x[COUNT_W-1:0];
            case (i_cmd.out_sel)
                OUT_TOP: begin
                    r_out_status <= ST_OK;
                    r_out_key    <= rd_ext[KEY_W-1:0];
                    r_out_rank   <= idx_next_x[RANK_W-1:0];
                    r_out_last   <= top_last;
                end
                default: begin
                    r_out_status <= r_status;
                    r_out_last   <= 1'b1;
                    if (r_op == OP_GET && r_status == ST_OK) begin
                        r_out_key  <= hi_ext[KEY_W-1:0];
                        r_out_rank <= r_rank;
                    end else begin
                        r_out_key  <= '0;
                        r_out_rank <= '0;
                    end
                end
            endcase
        end
    end

    assign o_out_valid   = r_out_vld;
    assign o_status      = r_out_status;
    assign o_key_out     = r_out_key;
    assign o_rank_out    = r_out_rank;
    assign o_entry_count = r_out_count;
    assign o_last        = r_out_last;

    // The entry count never passes the store depth.
    `TRL_ASSERT_IMPL(a_count_range, i_clk, i_rst_n, 1'b1, count_x <= XW'(DEPTH))
    // An append only writes when there is a free slot.
    `TRL_ASSERT_IMPL(a_append_room, i_clk, i_rst_n, i_cmd.wr_sel == WR_APPEND, r_count < CW'(DEPTH))

endmodule

// File: rtl/core/transpose_ranking_list.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Transpose ranking list
// Self-organising list of keys in rank order, with promotion by one place on
// every successful lookup.
// ----------------------------------------------------------------------------
// The block keeps up to DEPTH keys in rank order, rank 1 first. They sit in a
// key store with one write port and one registered read port. Every request
// beat produces exactly one result beat. The exception is read top, which
// produces one beat per key returned, with the last mark on the final one.
// The operations run as follows:
// - The search reads one entry per cycle. A miss answers contains, and add
//   then appends the key.
// - A key found at rank 1 is reported as it is; a key found further down is
//   first swapped with its neighbour.
// - Get by rank and down by rank read both neighbours and write them back.
//   Get at rank 1 reads only that one entry.
// - A request that fails its rank check goes straight to its result, as
//   do a down at the last rank, a contains on an empty list and an unknown
//   operation.
// - Read top reads each key in turn and loads its beat before the next read.
// The pace of all of these is set by the single read port of the key store,
// which visits one entry per cycle. A loaded result beat that is still held
// up downstream stalls the block until it is taken. A new request can be
// taken in the cycle after the previous one has loaded its last result beat
// into the output register. So a result may still be waiting downstream
// while the next request is already under way. The store itself needs no
// clearing after reset: only entries below the current count are ever read.
// ----------------------------------------------------------------------------

module transpose_ranking_list
    import trl_pkg::*;
#(
    parameter int DEPTH     = TRL_DEPTH,
    parameter int KEY_WIDTH = TRL_KEY_WIDTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    trl_in_if.sink     i_in,
    trl_out_if.source  o_out
);

    // Controller and datapath talk only through these two structs.
    t_trl_cmd cmd;
    t_trl_sts sts;
    logic     in_ready;

    trl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    trl_dp #(
        .DEPTH     (DEPTH),
        .KEY_WIDTH (KEY_WIDTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_operation   (i_in.operation),
        .i_key         (i_in.key),
        .i_rank        (i_in.rank),
        .i_out_ready   (o_out.ready),
        .o_out_valid   (o_out.valid),
        .o_status      (o_out.status),
        .o_key_out     (o_out.key_out),
        .o_rank_out    (o_out.rank_out),
        .o_entry_count (o_out.entry_count),
        .o_last        (o_out.last)
    );

    // The request channel is ready only while the controller waits in idle.
    assign i_in.ready = in_ready;

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Transpose ranking list testbench
// Drives request beats into the ranking list and checks every result beat
// against a shadow copy of the list kept inside the bench. A short table of
// hand-written requests comes first, followed by random traffic under several
// patterns of source gaps and sink back-pressure.
// ----------------------------------------------------------------------------
module tb;
    import trl_pkg::*;

    localparam int HALF_PERIOD_NS = 4;
    localparam int RESET_CYCLES   = 9;
    // Longest run of cycles with no beat moving on either channel. It covers
    // a full search plus swap, long random stalls and the drain at the end.
    localparam int STALL_LIMIT    = 4000;
    localparam int DRAIN_CYCLES   = 100;
    localparam int RANDOM_PER_PHASE = 76;

    // Operation codes the block does not define; they must answer a miss.
    localparam logic [OP_W-1:0] OP_RSVD_6 = 3'd6;
    localparam logic [OP_W-1:0] OP_RSVD_7 = 3'd7;

    // One result beat as it appears on the output channel.
    typedef struct packed {
        t_trl_status_code   status;
        logic [KEY_W-1:0]   key_out;
        logic [RANK_W-1:0]  rank_out;
        logic [COUNT_W-1:0] entry_count;
        logic               last;
    } t_beat;

    // One row of the hand-written part. Where typed is set, want holds the
    // single result beat read straight off the behaviour; otherwise the
    // shadow list supplies the expectation.
    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [KEY_W-1:0]  key;
        logic [RANK_W-1:0] rank;
        logic              typed;
        t_beat             want;
    } t_stim_row;

    localparam int N_DIRECTED = 25;

    // The list contents are tracked in the comments to the right of each row,
    // with rank 1 leftmost. F stands for all ones, A for 0xA5A5A5A5.
    t_stim_row directed_rows [N_DIRECTED] = '{
        // Empty list: every lookup misses and read top answers one miss beat.
        '{OP_READ_TOP, 32'h0000_0000, 7'd64, 1'b1, '{ST_MISS, 32'h0, 7'd0, 7'd0, 1'b1}},
        '{OP_GET,      32'h0000_0000, 7'd1,  1'b1, '{ST_MISS, 32'h0, 7'd0, 7'd0, 1'b1}},
        '{OP_DOWN,     32'h0000_0000, 7'd1,  1'b1, '{ST_MISS, 32'h0, 7'd0, 7'd0, 1'b1}},
        '{OP_CONTAINS, 32'h0000_0005, 7'd0,  1'b1, '{ST_MISS, 32'h0, 7'd0, 7'd0, 1'b1}},
        '{OP_RSVD_6,   32'hFFFF_FFFF, 7'd64, 1'b1, '{ST_MISS, 32'h0, 7'd0, 7'd0, 1'b1}},
        '{OP_RSVD_7,   32'h0000_0000, 7'd0,  1'b1, '{ST_MISS, 32'h0, 7'd0, 7'd0, 1'b1}},
        // Build [0 F A] through appends and an add of an absent key.
        '{OP_APPEND,   32'h0000_0000, 7'd0,  1'b1, '{ST_OK,   32'h0, 7'd0, 7'd1, 1'b1}},
        '{OP_APPEND,   32'hFFFF_FFFF, 7'd64, 1'b1, '{ST_OK,   32'h0, 7'd0, 7'd2, 1'b1}},
        '{OP_ADD,      32'hA5A5_A5A5, 7'd0,  1'b1, '{ST_OK,   32'h0, 7'd0, 7'd3, 1'b1}},
        // Add of a present key promotes it: [F 0 A].
        '{OP_ADD,      32'hFFFF_FFFF, 7'd0,  1'b1, '{ST_OK,   32'h0, 7'd0, 7'd3, 1'b1}},
        // Found at the front: nothing moves.
        '{OP_CONTAINS, 32'hFFFF_FFFF, 7'd0,  1'b1, '{ST_OK,   32'h0, 7'd0, 7'd3, 1'b1}},
        '{OP_CONTAINS, 32'h5A5A_5A5A, 7'd0,  1'b1, '{ST_MISS, 32'h0, 7'd0, 7'd3, 1'b1}},
        '{OP_GET,      32'h0000_0000, 7'd0,  1'b1, '{ST_MISS, 32'h0, 7'd0, 7'd3, 1'b1}},
        '{OP_GET,      32'h0000_0000, 7'd3,  1'b0, '0},    // [F A 0]
        '{OP_GET,      32'h0000_0000, 7'd4,  1'b1, '{ST_MISS, 32'h0, 7'd0, 7'd3, 1'b1}},
        '{OP_GET,      32'h0000_0000, 7'd1,  1'b0, '0},    // front stays
        '{OP_DOWN,     32'h0000_0000, 7'd1,  1'b0, '0},    // [A F 0]
        // Down at the last rank succeeds and changes nothing.
        '{OP_DOWN,     32'h0000_0000, 7'd3,  1'b1, '{ST_OK,   32'h0, 7'd0, 7'd3, 1'b1}},
        '{OP_DOWN,     32'h0000_0000, 7'd0,  1'b1, '{ST_MISS, 32'h0, 7'd0, 7'd3, 1'b1}},
        '{OP_DOWN,     32'h0000_0000, 7'd64, 1'b1, '{ST_MISS, 32'h0, 7'd0, 7'd3, 1'b1}},
        // A duplicate is stored by append; contains finds the first copy.
        '{OP_APPEND,   32'hA5A5_A5A5, 7'd0,  1'b1, '{ST_OK,   32'h0, 7'd0, 7'd4, 1'b1}},
        '{OP_CONTAINS, 32'hA5A5_A5A5, 7'd0,  1'b1, '{ST_OK,   32'h0, 7'd0, 7'd4, 1'b1}},
        '{OP_READ_TOP, 32'h0000_0000, 7'd0,  1'b1, '{ST_MISS, 32'h0, 7'd0, 7'd4, 1'b1}},
        '{OP_READ_TOP, 32'h0000_0000, 7'd2,  1'b0, '0},
        // Asking for more than is stored returns only what is stored.
        '{OP_READ_TOP, 32'h0000_0000, 7'd64, 1'b0, '0}
    };

    logic clk = 1'b0;
    logic rst_n;

    trl_in_if  req_ch ();
    trl_out_if rsp_ch ();

    transpose_ranking_list dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (req_ch),
        .o_out   (rsp_ch)
    );

    always #HALF_PERIOD_NS clk = ~clk;

    // ------------------------------------------------------------------------
    // Shadow copy of the ranked list and the result beats still awaited.
    // ------------------------------------------------------------------------
    logic [KEY_W-1:0] shadow_keys [TRL_DEPTH];
    int               shadow_count;
    t_beat            awaited_beats [$];

    int mismatch_count;
    int beat_no;
    int idle_cycles;
    int send_gap_pct;
    int stall_pct;

    function automatic t_beat make_beat(input t_trl_status_code st,
                                        input logic [KEY_W-1:0] k,
                                        input int r, input logic fin);
        t_beat b;
        b.status      = st;
        b.key_out     = k;
        b.rank_out    = RANK_W'(r);
        b.entry_count = COUNT_W'(shadow_count);
        b.last        = fin;
        return b;
    endfunction

    // Zero-based index of the first copy of k, or shadow_count when absent.
    function automatic int find_first(input logic [KEY_W-1:0] k);
        for (int i = 0; i < shadow_count; i++) begin
            if (shadow_keys[i] == k)
                return i;
        end
        return shadow_count;
    endfunction

    function automatic t_trl_status_code store_key(input logic [KEY_W-1:0] k);
        if (shadow_count >= TRL_DEPTH)
            return ST_FULL;
        shadow_keys[shadow_count] = k;
        shadow_count++;
        return ST_OK;
    endfunction

    // Swap the entry at zero-based index idx with the one in front of it.
    task automatic promote(input int idx);
        logic [KEY_W-1:0] held;
        held                 = shadow_keys[idx - 1];
        shadow_keys[idx - 1] = shadow_keys[idx];
        shadow_keys[idx]     = held;
    endtask

    // Applies one accepted request to the shadow list and queues the result
    // beats that the block must produce for it.
    task automatic apply_list_op(input logic [OP_W-1:0] op,
                                 input logic [KEY_W-1:0] key,
                                 input logic [RANK_W-1:0] rank);
        int               pos;
        int               r;
        int               n;
        logic [KEY_W-1:0] hit_key;
        t_trl_status_code st;
        r  = int'(rank);
        st = ST_MISS;
        case (op)
            OP_APPEND: begin
                st = store_key(key);
            end
            OP_ADD, OP_CONTAINS: begin
                pos = find_first(key);
                if (pos < shadow_count) begin
                    if (pos > 0)
                        promote(pos);
                    st = ST_OK;
                end else if (op == OP_ADD) begin
                    st = store_key(key);
                end
            end
            OP_GET: begin
                if (r != 0 && r <= shadow_count) begin
                    hit_key = shadow_keys[r - 1];
                    if (r > 1)
                        promote(r - 1);
                    awaited_beats.push_back(make_beat(ST_OK, hit_key, r, 1'b1));
                    return;
                end
            end
            OP_DOWN: begin
                // Demoting rank r is the same swap as promoting rank r + 1.
                if (r != 0 && r <= shadow_count) begin
                    if (r < shadow_count)
                        promote(r);
                    st = ST_OK;
                end
            end
            OP_READ_TOP: begin
                n = (r < shadow_count) ? r : shadow_count;
                if (n > 0) begin
                    for (int i = 0; i < n; i++)
                        awaited_beats.push_back(
                            make_beat(ST_OK, shadow_keys[i], i + 1, i + 1 == n));
                    return;
                end
            end
            default: begin
                st = ST_MISS;
            end
        endcase
        awaited_beats.push_back(make_beat(st, '0, 0, 1'b1));
    endtask

    // ------------------------------------------------------------------------
    // Request side. Entered and left at a falling edge; valid stays high from
    // one beat to the next unless a gap is drawn.
    // ------------------------------------------------------------------------
    task automatic send_request(input logic [OP_W-1:0] op,
                                input logic [KEY_W-1:0] key,
                                input logic [RANK_W-1:0] rank,
                                input logic typed, input t_beat want);
        while ($urandom_range(0, 99) < send_gap_pct) begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.operation <= op;
        req_ch.key       <= key;
        req_ch.rank      <= rank;
        do @(posedge clk); while (!req_ch.ready);
        apply_list_op(op, key, rank);
        // A hand-typed row always has exactly one result beat, so the one
        // just predicted is swapped for the typed one.
        if (typed) begin
            void'(awaited_beats.pop_back());
            awaited_beats.push_back(want);
        end
        @(negedge clk);
    endtask

    // Random request, weighted towards operations that hit stored keys so
    // that promotions and swaps happen often.
    task automatic send_random_request();
        int                roll;
        int                span;
        logic [OP_W-1:0]   op;
        logic [KEY_W-1:0]  key;
        logic [RANK_W-1:0] rank;
        roll = $urandom_range(0, 99);
        if (roll < 14)
            op = OP_APPEND;
        else if (roll < 40)
            op = OP_ADD;
        else if (roll < 58)
            op = OP_CONTAINS;
        else if (roll < 74)
            op = OP_GET;
        else if (roll < 86)
            op = OP_DOWN;
        else if (roll < 95)
            op = OP_READ_TOP;
        else
            op = $urandom_range(0, 1) ? OP_RSVD_7 : OP_RSVD_6;

        if (shadow_count > 0 && $urandom_range(0, 99) < 55)
            key = shadow_keys[$urandom_range(0, shadow_count - 1)];
        else if ($urandom_range(0, 7) == 0)
            key = $urandom_range(0, 1) ? '1 : '0;
        else
            key = $urandom;

        span = (shadow_count == 0) ? 1 : shadow_count;
        roll = $urandom_range(0, 9);
        if (op == OP_GET || op == OP_DOWN) begin
            if (roll < 7)
                rank = RANK_W'($urandom_range(1, span));
            else if (roll == 7)
                rank = '0;
            else if (roll == 8)
                rank = RANK_W'((shadow_count < TRL_DEPTH) ? shadow_count + 1 : TRL_DEPTH);
            else
                rank = RANK_W'($urandom_range(0, TRL_DEPTH));
        end else if (op == OP_READ_TOP) begin
            // Short reads mostly; long ones are costly under back-pressure.
            if (roll < 6)
                rank = RANK_W'($urandom_range(0, 6));
            else if (roll < 8)
                rank = RANK_W'($urandom_range(0, TRL_DEPTH));
            else if (roll == 8)
                rank = RANK_W'(TRL_DEPTH);
            else
                rank = RANK_W'(shadow_count);
        end else begin
            rank = RANK_W'($urandom_range(0, TRL_DEPTH));
        end
        send_request(op, key, rank, 1'b0, '0);
    endtask

    // ------------------------------------------------------------------------
    // Result side: ready is redrawn at every falling edge, and each beat is
    // compared with the oldest expectation at the rising edge that moves it.
    // ------------------------------------------------------------------------
    initial begin
        rsp_ch.ready = 1'b0;
        forever begin
            @(negedge clk);
            rsp_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    task automatic report_mismatch(input string what, input longint want, input longint got);
        mismatch_count++;
        $display("[%0t] result beat %0d: %s, expected 0x%0h, got 0x%0h",
                 $time, beat_no, what, want, got);
    endtask

    always @(posedge clk) begin : result_check
        t_beat want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (awaited_beats.size() == 0) begin
                report_mismatch("beat with nothing awaited", 0, rsp_ch.key_out);
            end else begin
                want = awaited_beats.pop_front();
                if (rsp_ch.status !== want.status)
                    report_mismatch("status", want.status, rsp_ch.status);
                if (rsp_ch.key_out !== want.key_out)
                    report_mismatch("key_out", want.key_out, rsp_ch.key_out);
                if (rsp_ch.rank_out !== want.rank_out)
                    report_mismatch("rank_out", want.rank_out, rsp_ch.rank_out);
                if (rsp_ch.entry_count !== want.entry_count)
                    report_mismatch("entry_count", want.entry_count, rsp_ch.entry_count);
                if (rsp_ch.last !== want.last)
                    report_mismatch("last", want.last, rsp_ch.last);
            end
            beat_no++;
        end
    end

    // Watchdog: any beat on either channel restarts the count.
    always @(posedge clk) begin
        if (!rst_n) begin
            idle_cycles <= 0;
        end else if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    initial begin : main_sequence
        int gap_plan   [4];
        int stall_plan [4];
        gap_plan   = '{0, 82, 0, 22};
        stall_plan = '{0, 0, 82, 22};

        mismatch_count   = 0;
        beat_no          = 0;
        shadow_count     = 0;
        send_gap_pct     = 0;
        stall_pct        = 0;
        rst_n            = 1'b0;
        req_ch.valid     = 1'b0;
        req_ch.operation = '0;
        req_ch.key       = '0;
        req_ch.rank      = '0;

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Hand-written part, run without gaps or back-pressure.
        foreach (directed_rows[i])
            send_request(directed_rows[i].op, directed_rows[i].key, directed_rows[i].rank,
                         directed_rows[i].typed, directed_rows[i].want);

        // Random part. The first phase runs flat out; the others add source
        // gaps, sink stalls or a mild mix of both. The list only grows, so
        // the later phases see it long and eventually full.
        for (int ph = 0; ph < 4; ph++) begin
            send_gap_pct = gap_plan[ph];
            stall_pct    = stall_plan[ph];
            if (ph == 3) begin
                // Make sure the full-list cases are reached: top the list
                // up, try to store one more, then read the whole list back.
                while (shadow_count < TRL_DEPTH)
                    send_request(OP_APPEND, $urandom, '0, 1'b0, '0);
                send_request(OP_APPEND, 32'h0BAD_F00D, '0, 1'b1,
                             '{ST_FULL, 32'h0, 7'd0, 7'(TRL_DEPTH), 1'b1});
                send_request(OP_ADD, $urandom, '0, 1'b0, '0);
                send_request(OP_READ_TOP, '0, 7'(TRL_DEPTH), 1'b0, '0);
            end
            repeat (RANDOM_PER_PHASE)
                send_random_request();
            // Hold the source off until the block has answered everything.
            req_ch.valid <= 1'b0;
            while (awaited_beats.size() != 0)
                @(negedge clk);
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
